@@ hdl/blmsa_pkg.sv @@
// ----------------------------------------------------------------------------
// blmsa_pkg
// Types, codes and pixel helpers for the bicolor LED matrix scan animator.
// ----------------------------------------------------------------------------
`default_nettype none

package blmsa_pkg;

  localparam int unsigned NUM_COLORS = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  // request codes
  localparam logic [1:0] REQ_SCAN  = 2'd0;
  localparam logic [1:0] REQ_RED   = 2'd1;
  localparam logic [1:0] REQ_GREEN = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_COLORS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_STEPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE      = 3'd7;

  localparam int unsigned COLOR_RED   = 0;
  localparam int unsigned COLOR_GREEN = 1;

  // row counter value that marks the frame boundary before the advance
  localparam logic [2:0] ROW_BEFORE_LAST = 3'd6;

  typedef logic [63:0] frame_t;  // row r in bits 8r+7..8r, bit n of a row = column n

  typedef struct packed {
    logic        on;
    logic [15:0] countdown;
    logic [7:0]  steps;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
  } anim_t;

  // one display row of a frame after rotation
  function automatic logic [7:0] rotated_row(input frame_t f, input logic [2:0] k,
                                             input logic [1:0] rot);
    logic [7:0] r;
    r = 8'h00;
    case (rot)
      ROT_0: begin
        r = f[{k, 3'b000} +: 8];
      end
      ROT_90: begin
        for (int j = 0; j < 8; j++) r[~3'(j)] = f[{3'(j), k}];
      end
      ROT_180: begin
        for (int j = 0; j < 8; j++) r[j] = f[{~k, ~3'(j)}];
      end
      ROT_270: begin
        for (int j = 0; j < 8; j++) r[j] = f[{3'(j), ~k}];
      end
      default: begin
        r = 8'h00;
      end
    endcase
    return r;
  endfunction

  // red bit i at 15-2i, green bit i at 14-2i
  function automatic logic [15:0] interleave(input logic [7:0] r, input logic [7:0] g);
    logic [15:0] w;
    for (int i = 0; i < 8; i++) begin
      w[4'(15 - 2 * i)] = r[i];
      w[4'(14 - 2 * i)] = g[i];
    end
    return w;
  endfunction

  // sprite placed at signed offset (px, py); pixels off the matrix drop out
  function automatic frame_t draw_sprite(input frame_t sprite, input logic [7:0] px,
                                         input logic [7:0] py);
    frame_t            f;
    logic signed [8:0] src;
    logic [7:0]        s;
    logic [7:0]        neg_px;
    f      = '0;
    neg_px = 8'(-px);
    for (int y = 0; y < 8; y++) begin
      src = 9'(y) - {py[7], py};
      s   = 8'h00;
      if (src >= 9'sd0 && src <= 9'sd7) begin
        s = sprite[{src[2:0], 3'b000} +: 8];
      end
      if (!px[7]) begin
        f[{3'(y), 3'b000} +: 8] = (px < 8'd8) ? (s << px[2:0]) : 8'h00;
      end else begin
        f[{3'(y), 3'b000} +: 8] = (neg_px < 8'd8) ? (s >> neg_px[2:0]) : 8'h00;
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ hdl/blmsa_in_if.sv @@
// ----------------------------------------------------------------------------
// blmsa_in_if
// Request channel: scan ticks and frame row writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface blmsa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] row_index;
  logic [7:0] row_data;
  logic [1:0] rotation;

  modport source (output valid, output req_type, output row_index, output row_data,
                  output rotation, input ready);
  modport sink   (input valid, input req_type, input row_index, input row_data,
                  input rotation, output ready);
endinterface

`default_nettype wire

@@ hdl/blmsa_out_if.sv @@
// ----------------------------------------------------------------------------
// blmsa_out_if
// Result channel: one driver word and row select per scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface blmsa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_word;
  logic [2:0]  row_select;

  modport source (output valid, output row_word, output row_select, input ready);
  modport sink   (input valid, input row_word, input row_select, output ready);
endinterface

`default_nettype wire

@@ hdl/bicolor_led_matrix_scan_animator.sv @@
// ----------------------------------------------------------------------------
// bicolor_led_matrix_scan_animator
// Red/green 8x8 frame buffers, row scan with rotation, sprite animation.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one request word: a scan tick or a red/green row write.
//   out_if carries one word per scan tick: the interleaved red/green column
//          bits for the driver shift register and the row to enable.
//   cfg_*  writes one animation register per cycle with cfg_we high; write
//          only while no request is in flight.
// Timing:
//   A request is captured in an input register and processed from there; a
//   scan tick's word lands in the output register, which drives out_if.valid,
//   once that register has room. One request per cycle is sustained while
//   out_if.ready is high; the input and output registers form a two-deep path.
// Stalls:
//   While out_if.ready is low the word holds; a pending scan tick waits in the
//   input register and in_if.ready drops. Row writes pass through regardless.
// Reset:
//   Synchronous rst_n clears frames, row counter, animation state and
//   configuration registers; both channels come up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bicolor_led_matrix_scan_animator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  blmsa_in_if.sink                                in_if,
  blmsa_out_if.source                             out_if,
  input  wire logic                               cfg_we,
  input  wire logic [blmsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [blmsa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers; anim_colors only triggers a restart
  logic [15:0] anim_period_r;
  logic [7:0]  anim_steps_r;
  logic [3:0]  delta_x_r;
  logic [3:0]  delta_y_r;
  logic [4:0]  start_x_r;
  logic [4:0]  start_y_r;
  blmsa_pkg::frame_t sprite_r;

  // input register
  logic       in_valid_r;
  logic [1:0] req_r;
  logic [2:0] idx_r;
  logic [7:0] data_r;
  logic [1:0] rot_r;

  // block state
  blmsa_pkg::frame_t frame_r   [blmsa_pkg::NUM_COLORS];
  blmsa_pkg::frame_t frame_nxt [blmsa_pkg::NUM_COLORS];
  blmsa_pkg::anim_t  anim_r    [blmsa_pkg::NUM_COLORS];
  blmsa_pkg::anim_t  anim_nxt  [blmsa_pkg::NUM_COLORS];
  logic [2:0]        scan_row_r;
  logic [2:0]        scan_row_nxt;

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] row_word_r;
  logic [15:0] row_word_nxt;
  logic [2:0]  row_select_r;
  logic [2:0]  row_select_nxt;

  logic adv;
  logic in_fire;
  logic out_load;
  logic [7:0] start_x_ext;
  logic [7:0] start_y_ext;
  logic [7:0] delta_x_ext;
  logic [7:0] delta_y_ext;

  assign start_x_ext = {{3{start_x_r[4]}}, start_x_r};
  assign start_y_ext = {{3{start_y_r[4]}}, start_y_r};
  assign delta_x_ext = {{4{delta_x_r[3]}}, delta_x_r};
  assign delta_y_ext = {{4{delta_y_r[3]}}, delta_y_r};

  // a scan tick needs room in the output register; anything else always moves
  assign adv = in_valid_r && ((req_r != blmsa_pkg::REQ_SCAN) || !out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || adv;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid      = out_valid_r;
  assign out_if.row_word   = row_word_r;
  assign out_if.row_select = row_select_r;

  always_comb begin
    frame_nxt      = frame_r;
    anim_nxt       = anim_r;
    scan_row_nxt   = scan_row_r;
    row_word_nxt   = row_word_r;
    row_select_nxt = row_select_r;
    out_load       = 1'b0;

    if (adv) begin
      case (req_r)
        blmsa_pkg::REQ_RED: begin
          frame_nxt[blmsa_pkg::COLOR_RED][{idx_r, 3'b000} +: 8] = data_r;
          anim_nxt[blmsa_pkg::COLOR_RED].on = 1'b0;
        end
        blmsa_pkg::REQ_GREEN: begin
          frame_nxt[blmsa_pkg::COLOR_GREEN][{idx_r, 3'b000} +: 8] = data_r;
          anim_nxt[blmsa_pkg::COLOR_GREEN].on = 1'b0;
        end
        blmsa_pkg::REQ_SCAN: begin
          out_load       = 1'b1;
          row_select_nxt = scan_row_r;
          row_word_nxt   = blmsa_pkg::interleave(
            blmsa_pkg::rotated_row(frame_r[blmsa_pkg::COLOR_RED], scan_row_r, rot_r),
            blmsa_pkg::rotated_row(frame_r[blmsa_pkg::COLOR_GREEN], scan_row_r, rot_r));
          scan_row_nxt   = scan_row_r + 3'd1;
          // frame boundary: counter moves onto the last row
          if (scan_row_r == blmsa_pkg::ROW_BEFORE_LAST) begin
            for (int c = 0; c < blmsa_pkg::NUM_COLORS; c++) begin
              if (anim_r[c].on) begin
                if (anim_r[c].countdown != 16'd0) begin
                  anim_nxt[c].countdown = anim_r[c].countdown - 16'd1;
                end else begin
                  anim_nxt[c].countdown = anim_period_r;
                  frame_nxt[c] = blmsa_pkg::draw_sprite(sprite_r, anim_r[c].pos_x,
                                                        anim_r[c].pos_y);
                  if (anim_r[c].steps != 8'd0) begin
                    anim_nxt[c].steps = anim_r[c].steps - 8'd1;
                    anim_nxt[c].pos_x = anim_r[c].pos_x + delta_x_ext;
                    anim_nxt[c].pos_y = anim_r[c].pos_y + delta_y_ext;
                  end else begin
                    anim_nxt[c].steps = anim_steps_r;
                    anim_nxt[c].pos_x = start_x_ext;
                    anim_nxt[c].pos_y = start_y_ext;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // restart the selected colors
    if (cfg_we && cfg_index == blmsa_pkg::CFG_ANIM_COLORS) begin
      for (int c = 0; c < blmsa_pkg::NUM_COLORS; c++) begin
        if (cfg_wdata[c]) begin
          anim_nxt[c].on        = (anim_period_r != 16'd0);
          anim_nxt[c].countdown = anim_period_r;
          anim_nxt[c].steps     = anim_steps_r;
          anim_nxt[c].pos_x     = start_x_ext;
          anim_nxt[c].pos_y     = start_y_ext;
        end
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_period_r <= '0;
      anim_steps_r  <= '0;
      delta_x_r     <= '0;
      delta_y_r     <= '0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      sprite_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        blmsa_pkg::CFG_ANIM_PERIOD: anim_period_r <= cfg_wdata[15:0];
        blmsa_pkg::CFG_ANIM_STEPS:  anim_steps_r  <= cfg_wdata[7:0];
        blmsa_pkg::CFG_DELTA_X:     delta_x_r     <= cfg_wdata[3:0];
        blmsa_pkg::CFG_DELTA_Y:     delta_y_r     <= cfg_wdata[3:0];
        blmsa_pkg::CFG_START_X:     start_x_r     <= cfg_wdata[4:0];
        blmsa_pkg::CFG_START_Y:     start_y_r     <= cfg_wdata[4:0];
        blmsa_pkg::CFG_SPRITE:      sprite_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_row_r  <= '0;
      for (int c = 0; c < blmsa_pkg::NUM_COLORS; c++) begin
        frame_r[c] <= '0;
        anim_r[c]  <= '0;
      end
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      scan_row_r  <= scan_row_nxt;
      for (int c = 0; c < blmsa_pkg::NUM_COLORS; c++) begin
        frame_r[c] <= frame_nxt[c];
        anim_r[c]  <= anim_nxt[c];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_if.req_type;
      idx_r  <= in_if.row_index;
      data_r <= in_if.row_data;
      rot_r  <= in_if.rotation;
    end
    row_word_r   <= row_word_nxt;
    row_select_r <= row_select_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/blmsa_checker.sv @@
// ----------------------------------------------------------------------------
// blmsa_checker
// Port-level checks for the bicolor LED matrix scan animator.
// ----------------------------------------------------------------------------
`default_nettype none

module blmsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_row_word,
  input wire logic [2:0]  out_row_select
);

  logic       in_scan_fire;
  logic       out_fire;
  logic [1:0] pend_r;
  logic       seen_r;
  logic [2:0] prev_sel_r;

  assign in_scan_fire = in_valid && in_ready && (in_req_type == blmsa_pkg::REQ_SCAN);
  assign out_fire     = out_valid && out_ready;

  // scan ticks accepted but whose word is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      seen_r     <= 1'b0;
      prev_sel_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_scan_fire) - 2'(out_fire);
      if (out_fire) begin
        seen_r     <= 1'b1;
        prev_sel_r <= out_row_select;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_word)
                                && $stable(out_row_select))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && seen_r |-> out_row_select == prev_sel_r + 3'd1)
    else $error("row select skipped or repeated");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending scan tick");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more scan ticks in flight than stages");

endmodule

bind bicolor_led_matrix_scan_animator blmsa_checker u_blmsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_req_type    (in_if.req_type),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_row_word   (out_if.row_word),
  .out_row_select (out_if.row_select)
);

`default_nettype wire
